/* hdl/bgc_pkg.sv */
// shared types and constants for the button gesture classifier
// no dependencies; imported by bgc_classifier and button_gesture_classifier
package bgc_pkg;

  localparam int TIME_W  = 32;
  localparam int THRESH_W = 16;
  localparam int INTENT_W = 2;
  localparam int CFG_IDX_W = 8;

  // intent codes
  localparam logic [INTENT_W-1:0] INTENT_NO_GESTURE = 2'd0;
  localparam logic [INTENT_W-1:0] INTENT_SINGLE     = 2'd1;
  localparam logic [INTENT_W-1:0] INTENT_LONG       = 2'd2;
  localparam logic [INTENT_W-1:0] INTENT_DOUBLE     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP_TIME = 8'd1;

  // register reset values in ms
  localparam logic [THRESH_W-1:0] LONG_PRESS_TIME_RST = 16'd800;
  localparam logic [THRESH_W-1:0] DOUBLE_GAP_TIME_RST = 16'd350;

  // thresholds handed to the classifier
  typedef struct packed {
    logic [THRESH_W-1:0] long_press_time;
    logic [THRESH_W-1:0] double_gap_time;
  } bgc_cfg_t;

endpackage

/* hdl/bgc_classifier.sv */
// gesture state and per-poll decision logic
// depends on bgc_pkg; instantiated by button_gesture_classifier
module bgc_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           enable,
  input  logic                           held,
  input  logic [bgc_pkg::TIME_W-1:0]     now,
  input  bgc_pkg::bgc_cfg_t              cfg,
  output logic [bgc_pkg::INTENT_W-1:0]   intent
);
  import bgc_pkg::*;

  logic                prev_pressed, prev_pressed_next;
  logic [TIME_W-1:0]   press_start_time, press_start_time_next;
  logic [TIME_W-1:0]   release_time, release_time_next;
  logic                long_done, long_done_next;
  logic                single_pending, single_pending_next;

  logic                press_edge;
  logic                long_done_eff;
  logic [TIME_W-1:0]   press_start_eff;
  logic [TIME_W-1:0]   held_for;
  logic [TIME_W-1:0]   since_release;
  logic                long_hit;
  logic                gap_within;
  logic                gap_expired;

  // press edge restarts the press timer
  assign press_edge      = held && !prev_pressed;
  assign press_start_eff = press_edge ? now : press_start_time;
  assign long_done_eff   = press_edge ? 1'b0 : long_done;

  // wrapping time differences against the thresholds
  assign held_for      = now - press_start_eff;
  assign since_release = now - release_time;
  assign long_hit      = held && !long_done_eff &&
                         (held_for > {{(TIME_W-THRESH_W){1'b0}}, cfg.long_press_time});
  assign gap_within    = since_release < {{(TIME_W-THRESH_W){1'b0}}, cfg.double_gap_time};
  assign gap_expired   = since_release > {{(TIME_W-THRESH_W){1'b0}}, cfg.double_gap_time};

  // ordered checks: long press, release edge, pending single
  always_comb begin
    prev_pressed_next     = held;
    press_start_time_next = press_start_eff;
    release_time_next     = release_time;
    long_done_next        = long_done_eff;
    single_pending_next   = single_pending;
    intent                = INTENT_NO_GESTURE;
    priority if (long_hit) begin
      long_done_next = 1'b1;
      intent         = INTENT_LONG;
    end else if (!held && prev_pressed) begin
      if (long_done_eff) begin
        intent = INTENT_NO_GESTURE;
      end else if (single_pending && gap_within) begin
        single_pending_next = 1'b0;
        intent              = INTENT_DOUBLE;
      end else begin
        single_pending_next = 1'b1;
        release_time_next   = now;
      end
    end else if (single_pending && gap_expired) begin
      single_pending_next = 1'b0;
      intent              = INTENT_SINGLE;
    end else begin
      intent = INTENT_NO_GESTURE;
    end
  end

  // state update once per poll
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pressed     <= 1'b0;
      press_start_time <= '0;
      release_time     <= '0;
      long_done        <= 1'b0;
      single_pending   <= 1'b0;
    end else if (enable) begin
      prev_pressed     <= prev_pressed_next;
      press_start_time <= press_start_time_next;
      release_time     <= release_time_next;
      long_done        <= long_done_next;
      single_pending   <= single_pending_next;
    end
  end

  // a long press is reported only while held
  a_long_held: assert property (@(posedge clk) disable iff (rst)
    enable && (intent == INTENT_LONG) |-> held)
    else $error("long press reported while released");

  // a double press consumes the pending single press
  a_double_clears: assert property (@(posedge clk) disable iff (rst)
    enable && (intent == INTENT_DOUBLE) |=> !single_pending)
    else $error("pending single press survived a double press");

  // a long press is reported once per press
  a_long_once: assert property (@(posedge clk) disable iff (rst)
    enable && (intent == INTENT_LONG) |=> long_done)
    else $error("long press flag not set after report");

endmodule

/* hdl/button_gesture_classifier.sv */
// Button gesture classifier: each request is one poll of the button level
// and a millisecond timestamp, and gives exactly one intent (none, single,
// long or double press). A poll is taken every cycle unless in_stall is high;
// it waits in the input register, where it is decided against the stored
// gesture state, and its intent is then held in the result register, so
// throughput is one poll per cycle while the output is not stalled. The user
// must write thresholds through the configuration channel only while no poll
// is in flight; the block does not enforce this. cfg_ready is always high.
//
// top level; depends on bgc_pkg and bgc_classifier
module button_gesture_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            button_pressed,
  input  logic [bgc_pkg::TIME_W-1:0]      now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bgc_pkg::INTENT_W-1:0]    intent,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgc_pkg::THRESH_W-1:0]    cfg_data
);
  import bgc_pkg::*;

  bgc_cfg_t              cfg;
  logic                  s1_valid;
  logic                  s1_held;
  logic [TIME_W-1:0]     s1_now;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_accept;
  logic [INTENT_W-1:0]   core_intent;

  // handshake control
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_time <= LONG_PRESS_TIME_RST;
      cfg.double_gap_time <= DOUBLE_GAP_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LONG_PRESS_TIME) begin
        cfg.long_press_time <= cfg_data;
      end else if (cfg_index == REG_DOUBLE_GAP_TIME) begin
        cfg.double_gap_time <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_held <= button_pressed;
      s1_now  <= now_ms;
    end
  end

  // decision against stored gesture state
  bgc_classifier u_classifier (
    .clk    (clk),
    .rst    (rst),
    .enable (s1_fire),
    .held   (s1_held),
    .now    (s1_now),
    .cfg    (cfg),
    .intent (core_intent)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      intent <= core_intent;
    end
  end

  // input stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // every decided poll lands in the result register
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("decided poll lost");

  // an accepted request occupies the input register next cycle
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted request not held in input register");

endmodule
